// ----- rtl/crs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_pkg
// Shared constants and types for the Catmull-Rom spline evaluator.
// ----------------------------------------------------------------------------
package crs_pkg;

    localparam int MAX_POINTS  = 16;
    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 16;

    // Fixed field widths of the stream items.
    localparam int REQ_W    = 2;
    localparam int PIDX_W   = 4;
    localparam int CURVE_W  = 20;
    localparam int OUT_W    = 19;
    localparam int PCOUNT_W = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Derived widths.
    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int SEG_W  = CURVE_W - FRAC_BITS;
    localparam int CMP_BASE = (SEG_W > CNT_W) ? SEG_W : CNT_W;
    localparam int CMP_W  = ((CMP_BASE > PCOUNT_W) ? CMP_BASE : PCOUNT_W) + 2;
    localparam int WGT_W  = FRAC_BITS + 5;
    localparam int PROD_W = COORD_WIDTH + WGT_W;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 3;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_POS   = 2'd1,
        REQ_GRAD  = 2'd2
    } req_t;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'b1;

    typedef struct packed {
        logic                   en;
        logic [IDX_W-1:0]       addr;
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
    } pt_wr_t;

    typedef struct packed {
        logic                  en;
        logic [3:0][IDX_W-1:0] addr;
    } pt_rd_t;

endpackage

// ----- rtl/crs_point_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_point_ram
// Control point table: two identical banks of x/y words, each with one write
// port and two registered read ports, giving four reads per cycle.
// ----------------------------------------------------------------------------
module crs_point_ram
    import crs_pkg::*;
(
    input  logic                         clk,
    input  pt_wr_t                       wr,
    input  pt_rd_t                       rd,
    output logic [3:0][COORD_WIDTH-1:0]  rd_x,
    output logic [3:0][COORD_WIDTH-1:0]  rd_y
);

    logic [2*COORD_WIDTH-1:0] bank_a [MAX_POINTS];
    logic [2*COORD_WIDTH-1:0] bank_b [MAX_POINTS];
    logic [3:0][2*COORD_WIDTH-1:0] rd_data_reg;

    // Both banks take every write so that they always hold the same points.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            bank_a[wr.addr] <= {wr.y, wr.x};
            bank_b[wr.addr] <= {wr.y, wr.x};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg[0] <= bank_a[rd.addr[0]];
            rd_data_reg[1] <= bank_a[rd.addr[1]];
            rd_data_reg[2] <= bank_b[rd.addr[2]];
            rd_data_reg[3] <= bank_b[rd.addr[3]];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rd_x[i] = rd_data_reg[i][COORD_WIDTH-1:0];
            rd_y[i] = rd_data_reg[i][2*COORD_WIDTH-1:COORD_WIDTH];
        end
    end

endmodule

// ----- rtl/catmull_rom_spline_eval.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_spline_eval
// Uniform Catmull-Rom evaluator over a table of 2-D control points, giving
// position or gradient for a fixed-point curve parameter.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (low bit up)                     | tuser
//  s_axis   | in        | point_index, point_x, point_y, curve_p | req_type
//  m_axis   | out       | result_x, result_y, 2 zero bits        | is_gradient, out_of_range
//  cfg      | in        | cfg_index, cfg_data (always ready)     | -
//
// One item is taken per cycle while the pipeline is not backed up. There are
// seven register stages, the first loaded at the transfer edge: table read,
// the f^2 and f^3 multiplies, weights, coordinate products, pair sums, then
// rounding and saturation into the output register.
// Each stage holds under a stall only when the stage after it is full, so
// bubbles are squeezed out. Writes and unused request codes give no result.
// The point table is not cleared by reset; reset clears only valid bits and
// configuration registers.
// ----------------------------------------------------------------------------
module catmull_rom_spline_eval
    import crs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // point_index[3:0], point_x[19:4], point_y[35:20], curve_param[55:36]
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,
    // req_type[1:0]
    input  logic [REQ_W-1:0]        s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // result_x[18:0], result_y[37:19], zero fill[39:38]
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,
    // is_gradient[0], out_of_range[1]
    output logic [OUT_USER_W-1:0]   m_axis_tuser,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    // ---------------- input fields ----------------
    logic [PIDX_W-1:0]      in_pidx;
    logic [COORD_WIDTH-1:0] in_x;
    logic [COORD_WIDTH-1:0] in_y;
    logic [CURVE_W-1:0]     in_param;
    logic [SEG_W-1:0]       in_seg;
    logic [FRAC_BITS-1:0]   in_frac;

    assign in_pidx  = s_axis_tdata[PIDX_W-1:0];
    assign in_x     = s_axis_tdata[PIDX_W+COORD_WIDTH-1:PIDX_W];
    assign in_y     = s_axis_tdata[PIDX_W+2*COORD_WIDTH-1:PIDX_W+COORD_WIDTH];
    assign in_param = s_axis_tdata[PIDX_W+2*COORD_WIDTH+CURVE_W-1:PIDX_W+2*COORD_WIDTH];
    assign in_seg   = in_param[CURVE_W-1:FRAC_BITS];
    assign in_frac  = in_param[FRAC_BITS-1:0];

    // ---------------- configuration ----------------
    logic                loop_mode_reg;
    logic [PCOUNT_W-1:0] point_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_mode_reg   <= 1'b0;
            point_count_reg <= PCOUNT_W'(4);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LOOP_MODE:   loop_mode_reg   <= cfg_data[0];
                CFG_POINT_COUNT: point_count_reg <= cfg_data[PCOUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, out_valid_reg;
    logic en1, en2, en3, en4, en5, en6, en7;
    logic accept, eval_acc;
    req_t in_req;

    assign en7 = !out_valid_reg || m_axis_tready;
    assign en6 = !v6_reg || en7;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_axis_tready = en1;
    assign accept   = s_axis_tvalid && en1;
    assign in_req   = req_t'(s_axis_tuser);
    assign eval_acc = accept && (in_req == REQ_POS || in_req == REQ_GRAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= eval_acc;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
            if (en7) out_valid_reg <= v6_reg;
        end
    end

    // ---------------- index selection ----------------
    logic [CMP_W-1:0] pc_ext, n_pts, seg_ext, wr_ext;
    logic [CMP_W-1:0] idx0, idx1, idx2, idx3, seg_inc, idx2_inc;
    logic             oor_next, wr_ok;

    always_comb
    begin
        pc_ext  = CMP_W'(point_count_reg);
        seg_ext = CMP_W'(in_seg);
        wr_ext  = CMP_W'(in_pidx);
        wr_ok   = wr_ext < CMP_W'(MAX_POINTS);
        if (pc_ext < CMP_W'(4))
            n_pts = CMP_W'(4);
        else if (pc_ext > CMP_W'(MAX_POINTS))
            n_pts = CMP_W'(MAX_POINTS);
        else
            n_pts = pc_ext;

        seg_inc  = seg_ext + CMP_W'(1);
        idx2_inc = '0;
        if (loop_mode_reg)
        begin
            oor_next = seg_ext >= n_pts;
            idx1     = seg_ext;
            idx2     = (seg_inc == n_pts) ? '0 : seg_inc;
            idx2_inc = idx2 + CMP_W'(1);
            idx3     = (idx2_inc == n_pts) ? '0 : idx2_inc;
            idx0     = (seg_ext == '0) ? (n_pts - CMP_W'(1)) : (seg_ext - CMP_W'(1));
        end
        else
        begin
            // Open curve: segment s draws on points s to s+3.
            oor_next = (seg_ext + CMP_W'(3)) >= n_pts;
            idx0     = seg_ext;
            idx1     = seg_inc;
            idx2     = seg_ext + CMP_W'(2);
            idx3     = seg_ext + CMP_W'(3);
        end
    end

    // ---------------- point table ----------------
    pt_wr_t                      tbl_wr;
    pt_rd_t                      tbl_rd;
    logic [3:0][COORD_WIDTH-1:0] tbl_x, tbl_y;

    always_comb
    begin
        tbl_wr.en      = accept && (in_req == REQ_WRITE) && wr_ok;
        tbl_wr.addr    = wr_ext[IDX_W-1:0];
        tbl_wr.x       = in_x;
        tbl_wr.y       = in_y;
        tbl_rd.en      = eval_acc;
        tbl_rd.addr[0] = idx0[IDX_W-1:0];
        tbl_rd.addr[1] = idx1[IDX_W-1:0];
        tbl_rd.addr[2] = idx2[IDX_W-1:0];
        tbl_rd.addr[3] = idx3[IDX_W-1:0];
    end

    crs_point_ram u_point_ram
    (
        .clk  (clk),
        .wr   (tbl_wr),
        .rd   (tbl_rd),
        .rd_x (tbl_x),
        .rd_y (tbl_y)
    );

    // ---------------- datapath stages ----------------
    logic                        grad1_reg, grad2_reg, grad3_reg, grad4_reg, grad5_reg, grad6_reg;
    logic                        oor1_reg, oor2_reg, oor3_reg, oor4_reg, oor5_reg, oor6_reg;
    logic [FRAC_BITS-1:0]        f1_reg, f2_reg, f3_reg;
    logic [FRAC_BITS-1:0]        tt2_reg, tt3_reg, ttt3_reg;
    logic [3:0][COORD_WIDTH-1:0] x2_reg, y2_reg, x3_reg, y3_reg, x4_reg, y4_reg;
    logic signed [WGT_W-1:0]     q4_reg [4];
    logic signed [WGT_W-1:0]     q_next [4];
    logic signed [PROD_W-1:0]    px5_reg [4];
    logic signed [PROD_W-1:0]    py5_reg [4];
    logic signed [PROD_W-1:0]    px_next [4];
    logic signed [PROD_W-1:0]    py_next [4];
    logic signed [PAIR_W-1:0]    sx6_reg [2];
    logic signed [PAIR_W-1:0]    sy6_reg [2];
    logic [2*FRAC_BITS-1:0]      sq_prod, cube_prod;
    logic [OUT_W-1:0]            result_x_reg, result_y_reg;
    logic [OUT_W-1:0]            result_x_next, result_y_next;
    logic                        grad_out_reg, oor_out_reg;

    assign sq_prod   = f1_reg * f1_reg;
    assign cube_prod = tt2_reg * f2_reg;

    // Weights from f, f^2 and f^3; constant factors are shift-add terms.
    logic signed [WGT_W-1:0] wa, wb, wc, wone;

    always_comb
    begin
        wa   = $signed({{(WGT_W-FRAC_BITS){1'b0}}, f3_reg});
        wb   = $signed({{(WGT_W-FRAC_BITS){1'b0}}, tt3_reg});
        wc   = $signed({{(WGT_W-FRAC_BITS){1'b0}}, ttt3_reg});
        wone = $signed(WGT_W'(1) << FRAC_BITS);
        if (grad3_reg)
        begin
            q_next[0] = -((wb <<< 1) + wb) + (wa <<< 2) - wone;
            q_next[1] = ((wb <<< 3) + wb) - ((wa <<< 3) + (wa <<< 1));
            q_next[2] = -((wb <<< 3) + wb) + (wa <<< 3) + wone;
            q_next[3] = ((wb <<< 1) + wb) - (wa <<< 1);
        end
        else
        begin
            q_next[0] = -wc + (wb <<< 1) - wa;
            q_next[1] = ((wc <<< 1) + wc) - ((wb <<< 2) + wb) + (wone <<< 1);
            q_next[2] = -((wc <<< 1) + wc) + (wb <<< 2) + wa;
            q_next[3] = wc - wb;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            px_next[i] = $signed(x4_reg[i]) * q4_reg[i];
            py_next[i] = $signed(y4_reg[i]) * q4_reg[i];
        end
    end

    // Divide by 2^(FRAC_BITS+1) rounding half up, then clip to the output range.
    function automatic logic [OUT_W-1:0] round_sat(
        input logic signed [PAIR_W-1:0] lo,
        input logic signed [PAIR_W-1:0] hi
    );
        logic signed [SUM_W-1:0]    total;
        logic signed [SUM_W-1:0]    shifted;
        logic [SUM_W-OUT_W:0]       top_bits;
        logic [OUT_W-1:0]           res;
        total    = SUM_W'(lo) + SUM_W'(hi) + (SUM_W'(1) << FRAC_BITS);
        shifted  = total >>> (FRAC_BITS + 1);
        top_bits = shifted[SUM_W-1:OUT_W-1];
        if (top_bits == '0 || top_bits == '1)
            res = shifted[OUT_W-1:0];
        else if (shifted[SUM_W-1])
            res = {1'b1, {(OUT_W-1){1'b0}}};
        else
            res = {1'b0, {(OUT_W-1){1'b1}}};
        return res;
    endfunction

    always_comb
    begin
        if (oor6_reg)
        begin
            result_x_next = '0;
            result_y_next = '0;
        end
        else
        begin
            result_x_next = round_sat(sx6_reg[0], sx6_reg[1]);
            result_y_next = round_sat(sy6_reg[0], sy6_reg[1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            grad1_reg <= (in_req == REQ_GRAD);
            oor1_reg  <= oor_next;
            f1_reg    <= in_frac;
        end
        if (en2)
        begin
            grad2_reg <= grad1_reg;
            oor2_reg  <= oor1_reg;
            f2_reg    <= f1_reg;
            tt2_reg   <= sq_prod[2*FRAC_BITS-1:FRAC_BITS];
            x2_reg    <= tbl_x;
            y2_reg    <= tbl_y;
        end
        if (en3)
        begin
            grad3_reg <= grad2_reg;
            oor3_reg  <= oor2_reg;
            f3_reg    <= f2_reg;
            tt3_reg   <= tt2_reg;
            ttt3_reg  <= cube_prod[2*FRAC_BITS-1:FRAC_BITS];
            x3_reg    <= x2_reg;
            y3_reg    <= y2_reg;
        end
        if (en4)
        begin
            grad4_reg <= grad3_reg;
            oor4_reg  <= oor3_reg;
            q4_reg    <= q_next;
            x4_reg    <= x3_reg;
            y4_reg    <= y3_reg;
        end
        if (en5)
        begin
            grad5_reg <= grad4_reg;
            oor5_reg  <= oor4_reg;
            px5_reg   <= px_next;
            py5_reg   <= py_next;
        end
        if (en6)
        begin
            grad6_reg  <= grad5_reg;
            oor6_reg   <= oor5_reg;
            sx6_reg[0] <= PAIR_W'(px5_reg[0]) + PAIR_W'(px5_reg[1]);
            sx6_reg[1] <= PAIR_W'(px5_reg[2]) + PAIR_W'(px5_reg[3]);
            sy6_reg[0] <= PAIR_W'(py5_reg[0]) + PAIR_W'(py5_reg[1]);
            sy6_reg[1] <= PAIR_W'(py5_reg[2]) + PAIR_W'(py5_reg[3]);
        end
        if (en7)
        begin
            grad_out_reg <= grad6_reg;
            oor_out_reg  <= oor6_reg;
            result_x_reg <= result_x_next;
            result_y_reg <= result_y_next;
        end
    end

    // ---------------- outputs ----------------
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-2*OUT_W){1'b0}}, result_y_reg, result_x_reg};
    assign m_axis_tuser  = {oor_out_reg, grad_out_reg};

    // ---------------- assertions ----------------
    logic signed [WGT_W+1:0] wsum;

    assign wsum = (WGT_W+2)'(q4_reg[0]) + (WGT_W+2)'(q4_reg[1])
                + (WGT_W+2)'(q4_reg[2]) + (WGT_W+2)'(q4_reg[3]);

    // Input stalls only when every stage holds an item.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg
                            && v6_reg && out_valid_reg))
        else $error("input stalled while the pipeline has a bubble");

    // Position weights always sum to two in fixed point.
    a_pos_weights: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !grad4_reg) |-> (wsum == ((WGT_W+2)'(1) << (FRAC_BITS + 1))))
        else $error("position weights do not sum to two");

    // Gradient weights always cancel.
    a_grad_weights: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && grad4_reg) |-> (wsum == '0))
        else $error("gradient weights do not sum to zero");

    // A segment out of range for the point count yields a zero result.
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && oor_out_reg) |-> (result_x_reg == '0 && result_y_reg == '0))
        else $error("out-of-range result is not zero");

endmodule

// ----- test/spline_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spline_checker
// Watches the input, result and register channels of the spline evaluator.
// It keeps its own copy of the point table and the registers, works out
// the result of every accepted evaluate transfer, and compares each result
// transfer field by field with the oldest result still owed.
// ----------------------------------------------------------------------------
module spline_checker
    import crs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,
    input  logic [REQ_W-1:0]        s_axis_tuser,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic [OUT_USER_W-1:0]   m_axis_tuser,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output int unsigned             mismatches,
    output int unsigned             outstanding,
    output int unsigned             results_seen,
    output int unsigned             oor_seen,
    output int unsigned             grad_seen
);

    localparam int X_LSB     = PIDX_W;
    localparam int Y_LSB     = PIDX_W + COORD_WIDTH;
    localparam int PARAM_LSB = PIDX_W + 2 * COORD_WIDTH;
    localparam longint OUT_HI = 262143;
    localparam longint OUT_LO = -262144;

    typedef struct packed {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic             grad;
        logic             oor;
    } spline_result_t;

    logic [COORD_WIDTH-1:0] x_table [MAX_POINTS];
    logic [COORD_WIDTH-1:0] y_table [MAX_POINTS];
    logic                   loop_cfg  = 1'b0;
    logic [PCOUNT_W-1:0]    count_cfg = 5'd4;
    spline_result_t         owed_results [$];
    int unsigned            err_cnt  = 0;
    int unsigned            res_cnt  = 0;
    int unsigned            oor_cnt  = 0;
    int unsigned            grad_cnt = 0;

    // Divide by 2^(FRAC_BITS+1) rounding half up, then clip to the output range.
    function automatic logic [OUT_W-1:0] round_sat(input longint acc);
        longint r;
        r = (acc + (longint'(1) << FRAC_BITS)) >>> (FRAC_BITS + 1);
        if (r > OUT_HI)
            r = OUT_HI;
        if (r < OUT_LO)
            r = OUT_LO;
        return r[OUT_W-1:0];
    endfunction

    function automatic spline_result_t eval_spline(input logic [REQ_W-1:0] kind,
                                                   input logic [CURVE_W-1:0] param);
        spline_result_t res;
        int             n;
        int             seg;
        int             pick [4];
        longint         f;
        longint         tt;
        longint         ttt;
        longint         one;
        longint         w [4];
        longint         sx;
        longint         sy;
        res      = '0;
        res.grad = (kind == REQ_GRAD);
        n = int'(count_cfg);
        if (n < 4)
            n = 4;
        if (n > MAX_POINTS)
            n = MAX_POINTS;
        seg = int'(param[CURVE_W-1:FRAC_BITS]);
        if (!loop_cfg)
        begin
            if (seg + 3 >= n)
                res.oor = 1'b1;
            else
                for (int i = 0; i < 4; i++)
                    pick[i] = seg + i;
        end
        else
        begin
            if (seg >= n)
                res.oor = 1'b1;
            else
            begin
                // A closed curve borrows its neighbors across the seam.
                pick[1] = seg;
                pick[2] = (seg + 1) % n;
                pick[3] = (pick[2] + 1) % n;
                pick[0] = (seg >= 1) ? seg - 1 : n - 1;
            end
        end
        if (res.oor)
            return res;
        one = longint'(1) << FRAC_BITS;
        f   = longint'(param[FRAC_BITS-1:0]);
        tt  = (f * f) >>> FRAC_BITS;
        ttt = (tt * f) >>> FRAC_BITS;
        if (kind == REQ_POS)
        begin
            w[0] = -ttt + 2 * tt - f;
            w[1] = 3 * ttt - 5 * tt + 2 * one;
            w[2] = -3 * ttt + 4 * tt + f;
            w[3] = ttt - tt;
        end
        else
        begin
            w[0] = -3 * tt + 4 * f - one;
            w[1] = 9 * tt - 10 * f;
            w[2] = -9 * tt + 8 * f + one;
            w[3] = 3 * tt - 2 * f;
        end
        sx = 0;
        sy = 0;
        for (int i = 0; i < 4; i++)
        begin
            sx += longint'($signed(x_table[pick[i]])) * w[i];
            sy += longint'($signed(y_table[pick[i]])) * w[i];
        end
        res.x = round_sat(sx);
        res.y = round_sat(sy);
        return res;
    endfunction

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            err_cnt++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        spline_result_t want;
        if (!rst_n)
        begin
            owed_results.delete();
            loop_cfg  = 1'b0;
            count_cfg = 5'd4;
        end
        else
        begin
            // A result leaves only after its evaluate has passed every pipeline stage, so
            // the result side is settled before this edge's input is queued.
            if (m_axis_tvalid && m_axis_tready)
            begin
                res_cnt++;
                if (m_axis_tuser[1])
                    oor_cnt++;
                if (m_axis_tuser[0])
                    grad_cnt++;
                if (owed_results.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t ns: result transfer with none owed, tdata %h tuser %b",
                             $time, m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("result_x", int'($signed(want.x)),
                                int'($signed(m_axis_tdata[OUT_W-1:0])));
                    check_field("result_y", int'($signed(want.y)),
                                int'($signed(m_axis_tdata[2*OUT_W-1:OUT_W])));
                    check_field("is_gradient", int'(want.grad), int'(m_axis_tuser[0]));
                    check_field("out_of_range", int'(want.oor), int'(m_axis_tuser[1]));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LOOP_MODE:   loop_cfg  = cfg_data[0];
                    CFG_POINT_COUNT: count_cfg = cfg_data;
                    default:         ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                case (s_axis_tuser)
                    REQ_WRITE:
                    begin
                        x_table[s_axis_tdata[PIDX_W-1:0]] =
                            s_axis_tdata[X_LSB +: COORD_WIDTH];
                        y_table[s_axis_tdata[PIDX_W-1:0]] =
                            s_axis_tdata[Y_LSB +: COORD_WIDTH];
                    end
                    REQ_POS, REQ_GRAD:
                        owed_results.insert(owed_results.size(),
                            eval_spline(s_axis_tuser, s_axis_tdata[PARAM_LSB +: CURVE_W]));
                    default: ;
                endcase
            end
        end
        mismatches   <= err_cnt;
        outstanding  <= owed_results.size();
        results_seen <= res_cnt;
        oor_seen     <= oor_cnt;
        grad_seen    <= grad_cnt;
    end

endmodule

// ----- test/catmull_rom_spline_eval_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_spline_eval_test
// Loads the point table, runs a directed set of evaluations over the segment
// edges, the wrap-around of closed curves and the point count limits, then
// random write and evaluate traffic under nine register settings and three
// handshake idling patterns, including a long output stall.
// ----------------------------------------------------------------------------
module catmull_rom_spline_eval_test;
    import crs_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_PER_SETTING = 230;
    localparam int DRAIN_CYCLES       = 16;
    localparam int HOLD_CYCLES        = 200;
    localparam int CYCLE_LIMIT        = 400000;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [REQ_W-1:0]       s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [OUT_USER_W-1:0]  m_axis_tuser;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned results_seen;
    int unsigned oor_seen;
    int unsigned grad_seen;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_asks     = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;
    int          cycle_cnt     = 0;
    int unsigned items_sent    = 0;
    int unsigned writes_sent   = 0;
    logic        loop_sel      = 1'b0;
    int          eff_count     = 4;

    int loop_plan  [9] = '{0, 1, 0, 1, 0, 1, 1, 0, 1};
    int count_plan [9] = '{16, 16, 0, 4, 31, 9, 3, 17, 12};

    always #2 clk = ~clk;

    catmull_rom_spline_eval DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    spline_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .results_seen  (results_seen),
        .oor_seen      (oor_seen),
        .grad_seen     (grad_seen)
    );

    // Result side: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_asks != hold_served)
        begin
            hold_served = hold_asks;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results owed", cycle_cnt, outstanding);
            $display("catmull_rom_spline_eval_test NOT OK");
            $finish;
        end
    end

    task automatic send_item(input logic [REQ_W-1:0] kind, input logic [PIDX_W-1:0] idx,
                             input logic [COORD_WIDTH-1:0] px,
                             input logic [COORD_WIDTH-1:0] py,
                             input logic [CURVE_W-1:0] param);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {param, py, px, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (kind == REQ_WRITE)
            writes_sent++;
    endtask

    // Drop the input, wait for every owed result, then let the pipe empty of
    // writes and unused codes, which leave no result behind them.
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_curve(input logic loop_v, input int count_v);
        drain();
        // The upper data bits are junk for the loop flag register.
        write_reg(CFG_LOOP_MODE, {4'($urandom), loop_v});
        write_reg(CFG_POINT_COUNT, CFG_DATA_W'(count_v));
        loop_sel  = loop_v;
        eff_count = (count_v < 4) ? 4 : (count_v > MAX_POINTS) ? MAX_POINTS : count_v;
    endtask

    function automatic logic [COORD_WIDTH-1:0] rand_coord();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [FRAC_BITS-1:0] rand_frac();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_item();
        int                 pick;
        int                 seg;
        logic [REQ_W-1:0]   kind;
        pick = $urandom_range(99);
        if (pick < 14)
            send_item(REQ_WRITE, 4'($urandom), rand_coord(), rand_coord(), 20'($urandom));
        else if (pick < 17)
            send_item(REQ_UNUSED, 4'($urandom), 16'($urandom), 16'($urandom),
                      20'($urandom));
        else
        begin
            kind = $urandom_range(1) ? REQ_GRAD : REQ_POS;
            if ($urandom_range(9) == 0)
                seg = $urandom_range(15);
            else if (loop_sel)
                seg = $urandom_range(eff_count - 1);
            else
                seg = $urandom_range(eff_count - 4);
            send_item(kind, 4'($urandom), 16'($urandom), 16'($urandom),
                      {4'(seg), rand_frac()});
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Fill every table entry first so that no evaluation reads stale data.
        send_item(REQ_WRITE, 4'd0, 16'h8000, 16'h7fff, '0);
        send_item(REQ_WRITE, 4'd1, 16'h7fff, 16'h8000, '0);
        send_item(REQ_WRITE, 4'd2, 16'h0000, 16'h0000, '0);
        for (int i = 3; i < MAX_POINTS; i++)
            send_item(REQ_WRITE, PIDX_W'(i), rand_coord(), rand_coord(), 20'($urandom));

        // Reset registers: open curve of four points, only segment zero exists.
        send_item(REQ_POS, '0, '0, '0, 20'h00000);
        send_item(REQ_GRAD, '0, '0, '0, 20'h0ffff);
        send_item(REQ_POS, '0, '0, '0, 20'h10000);
        send_item(REQ_UNUSED, 4'hf, 16'hffff, 16'hffff, 20'hfffff);

        // Closed curve over the full table: both seams.
        set_curve(1'b1, 16);
        send_item(REQ_POS, '0, '0, '0, 20'h08000);
        send_item(REQ_GRAD, '0, '0, '0, 20'hfffff);
        send_item(REQ_POS, '0, '0, '0, 20'he4000);

        // Short closed curve: last segment, and two past it.
        set_curve(1'b1, 5);
        send_item(REQ_POS, '0, '0, '0, 20'h4c000);
        send_item(REQ_GRAD, '0, '0, '0, 20'h50000);
        send_item(REQ_POS, '0, '0, '0, 20'hf0001);

        // Open curve over the full table: last segment and the one past it.
        set_curve(1'b0, 16);
        send_item(REQ_POS, '0, '0, '0, 20'hcffff);
        send_item(REQ_GRAD, '0, '0, '0, 20'hd0000);
        send_item(REQ_WRITE, 4'd15, 16'h7fff, 16'h8000, '0);
        send_item(REQ_GRAD, '0, '0, '0, 20'hcffff);

        for (int m = 0; m < 3; m++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                set_curve(loop_plan[m*3+k][0], count_plan[m*3+k]);
                case (m)
                    0:       begin send_idle_pct = 27; recv_idle_pct = 78; end
                    1:       begin send_idle_pct = 78; recv_idle_pct = 27; end
                    default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                endcase
                // With the input running flat out, a long output stall backs
                // the pipeline up into the input handshake.
                if (m == 2 && k == 0)
                    hold_asks++;
                repeat (RANDOM_PER_SETTING) random_item();
            end
        end

        drain();
        $display("Sent %0d items, %0d of them table writes, over nine register settings",
                 items_sent, writes_sent);
        $display("and three idling patterns; %0d results checked, %0d gradients, %0d out of range.",
                 results_seen, grad_seen, oor_seen);
        if (mismatches == 0)
            $display("catmull_rom_spline_eval_test OK");
        else
            $display("catmull_rom_spline_eval_test NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/crs_pkg.sv
rtl/crs_point_ram.sv
rtl/catmull_rom_spline_eval.sv
test/spline_checker.sv
test/catmull_rom_spline_eval_test.sv
